// File: hdl/dats_pkg.sv
// Shared constants, register codes and sine table for the alarm tone sequencer.
`default_nettype none
package dats_pkg;

   localparam int NUM_STEPS_DEFAULT = 6;
   localparam int STEP_REGS         = 6;
   localparam int PHASE_BITS        = 16;
   localparam int SINE_ENTRIES      = 256;
   localparam int SINE_ADDR_BITS    = $clog2(SINE_ENTRIES);
   localparam int STEP_IDX_BITS     = 3;
   localparam int DUR_BITS          = 32;
   localparam int STEP_WORD_BITS    = DUR_BITS + PHASE_BITS;
   localparam int BOUND_BITS        = 4 * STEP_IDX_BITS;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int SAMPLE_BITS       = 8;
   localparam int REQ_TDATA_BITS    = 8;
   localparam int RSP_TDATA_BITS    = 16;

   typedef logic [STEP_WORD_BITS-1:0] step_word_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_STEP0  = 3'd1,
      CSR_STEP1  = 3'd2,
      CSR_STEP2  = 3'd3,
      CSR_STEP3  = 3'd4,
      CSR_STEP4  = 3'd5,
      CSR_STEP5  = 3'd6,
      CSR_BOUNDS = 3'd7
   } csr_index_type;

   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SWITCH = 1'b1;

   localparam step_word_type STEP_RESET [STEP_REGS] = '{
      48'd6751688597124, 48'd7812, 48'd9006546435337,
      48'd15625, 48'd6751688604937, 48'd15625
   };
   localparam logic [BOUND_BITS-1:0] BOUNDS_RESET = 12'd2632;

   // floor(127.5*sin(pi*j/128)) for the first quarter wave, j = 0..64
   localparam logic [6:0] QUARTER_ROM [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,  7'd12,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
       7'd30,  7'd34,  7'd37,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,
       7'd60,  7'd62,  7'd65,  7'd68,  7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd83,
       7'd85,  7'd87,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98, 7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
      7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
      7'd126, 7'd127, 7'd127, 7'd127, 7'd127
   };

   // Full-wave sine built from the quarter table by symmetry.
   function automatic logic [SAMPLE_BITS-1:0] sine_rom(logic [SINE_ADDR_BITS-1:0] k);
      logic [6:0] idx;
      logic       upper;
      idx   = '0;
      upper = 1'b1;
      if (k <= 8'd64) begin
         idx = k[6:0];
      end else if (k <= 8'd128) begin
         idx = 7'(8'd128 - k);
      end else if (k <= 8'd192) begin
         idx   = 7'(k - 8'd128);
         upper = 1'b0;
      end else begin
         idx   = 7'(8'd0 - k);
         upper = 1'b0;
      end
      if (upper) begin
         sine_rom = 8'd128 + {1'b0, QUARTER_ROM[idx]};
      end else begin
         sine_rom = 8'd127 - {1'b0, QUARTER_ROM[idx]};
      end
   endfunction

endpackage
`default_nettype wire

// File: hdl/dds_alarm_tone_sequencer.sv
// Top level of the alarm tone sequencer: phase accumulator, step sequencer and sine lookup.
//
//   channel  | ports              | payload
//   ---------+--------------------+----------------------------------------------
//   request  | req_tvalid/tready  | tuser: mode; tdata[0]: pattern_select
//   response | rsp_tvalid/tready  | tdata[7:0] sample_value, [10:8] current_step
//   config   | csr_we/index/wdata | register index 0..7, data up to 48 bits
//
// One transfer in gives one transfer out. The whole update (count down,
// step advance, word reload, phase add, sine lookup) runs in the cycle the
// request is taken and lands in the response register, so one item per cycle
// unless the receiver stalls. The request side is ready whenever the response
// register is empty or being drained the same cycle. Synchronous active-high
// reset restores the default tone program and empties the response register.
`default_nettype none
module dds_alarm_tone_sequencer #(
   parameter int NUM_STEPS = dats_pkg::NUM_STEPS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [dats_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // [0] pattern_select
   input  wire logic                                  req_tuser,  // [0] mode
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [dats_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,  // [7:0] sample, [10:8] step
   input  wire logic                                  csr_we,
   input  wire logic [dats_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [dats_pkg::STEP_WORD_BITS-1:0]   csr_wdata
);

   localparam int SB = dats_pkg::STEP_IDX_BITS;
   localparam int PB = dats_pkg::PHASE_BITS;
   localparam int DB = dats_pkg::DUR_BITS;
   localparam int AB = dats_pkg::SINE_ADDR_BITS;
   localparam logic [SB-1:0] LAST_STEP = SB'(NUM_STEPS - 1);

   // configuration registers
   logic                                 enable_ff;
   dats_pkg::step_word_type              step_word_ff [dats_pkg::STEP_REGS];
   logic [dats_pkg::BOUND_BITS-1:0]      bounds_ff;

   // tone state
   logic [PB-1:0] accum_ff,   accum_in;
   logic [PB-1:0] pstep_ff,   pstep_in;
   logic [DB-1:0] left_ff,    left_in;
   logic [SB-1:0] idx_ff,     idx_in;
   logic          pattern_ff, pattern_in;
   logic [dats_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;

   // response register
   logic                                 rsp_valid_ff;
   logic [dats_pkg::RSP_TDATA_BITS-1:0]  rsp_data_ff;

   logic          accept;
   logic          pat;
   logic [SB-1:0] start_step, stop_step, idx_inc, load_idx;
   logic [DB-1:0] left_dec;
   logic          load;
   dats_pkg::step_word_type load_word;

   function automatic logic [SB-1:0] bound_field(logic [dats_pkg::BOUND_BITS-1:0] b,
                                                 logic p, logic which);
      logic [SB-1:0] v;
      v = b[{p, which} * SB +: SB];
      bound_field = (v > LAST_STEP) ? LAST_STEP : v;
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Pattern in force for this item: a switch picks its own, a tick keeps the active one.
   assign pat        = (req_tuser == dats_pkg::MODE_SWITCH) ? req_tdata[0] : pattern_ff;
   assign start_step = bound_field(bounds_ff, pat, 1'b0);
   assign stop_step  = bound_field(bounds_ff, pat, 1'b1);
   assign left_dec   = left_ff - DB'(1);
   assign idx_inc    = idx_ff + SB'(1);

   always_comb begin
      accum_in   = accum_ff;
      pstep_in   = pstep_ff;
      left_in    = left_ff;
      idx_in     = idx_ff;
      pattern_in = pattern_ff;
      sample_in  = sample_ff;
      load       = 1'b0;
      load_idx   = idx_ff;
      if (req_tuser == dats_pkg::MODE_SWITCH) begin
         pattern_in = req_tdata[0];
         load_idx   = start_step;
         load       = 1'b1;
      end else if (enable_ff) begin
         left_in = left_dec;
         if (left_dec == '0) begin
            // advance, wrapping past the stop step back to the start
            load_idx = (idx_inc > stop_step) ? start_step : idx_inc;
            load     = 1'b1;
         end
      end
      // steps without a register read as an all-zero word
      load_word = (load_idx < SB'(dats_pkg::STEP_REGS)) ? step_word_ff[load_idx] : '0;
      if (load) begin
         idx_in   = load_idx;
         left_in  = load_word[DB-1:0];
         pstep_in = load_word[DB +: PB];
      end
      if (req_tuser == dats_pkg::MODE_TICK && enable_ff) begin
         accum_in  = accum_ff + pstep_in;
         sample_in = dats_pkg::sine_rom(accum_in[PB-1 -: AB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         bounds_ff <= dats_pkg::BOUNDS_RESET;
         for (int i = 0; i < dats_pkg::STEP_REGS; i++) begin
            step_word_ff[i] <= dats_pkg::STEP_RESET[i];
         end
      end else if (csr_we) begin
         case (csr_index)
            dats_pkg::CSR_ENABLE: enable_ff <= csr_wdata[0];
            dats_pkg::CSR_STEP0:  step_word_ff[0] <= csr_wdata;
            dats_pkg::CSR_STEP1:  step_word_ff[1] <= csr_wdata;
            dats_pkg::CSR_STEP2:  step_word_ff[2] <= csr_wdata;
            dats_pkg::CSR_STEP3:  step_word_ff[3] <= csr_wdata;
            dats_pkg::CSR_STEP4:  step_word_ff[4] <= csr_wdata;
            dats_pkg::CSR_STEP5:  step_word_ff[5] <= csr_wdata;
            dats_pkg::CSR_BOUNDS: bounds_ff <= csr_wdata[dats_pkg::BOUND_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         pstep_ff     <= '0;
         left_ff      <= DB'(1);
         idx_ff       <= SB'(1);
         pattern_ff   <= 1'b0;
         sample_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            accum_ff     <= accum_in;
            pstep_ff     <= pstep_in;
            left_ff      <= left_in;
            idx_ff       <= idx_in;
            pattern_ff   <= pattern_in;
            sample_ff    <= sample_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            // drop the response once it has been taken
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the payload until the next accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {5'd0, idx_in, sample_in};
      end
   end

endmodule
`default_nettype wire

// File: tb/tb_dds_alarm_tone_sequencer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the alarm tone sequencer: stream stimulus, tone predictor, checks.
module tb_dds_alarm_tone_sequencer;

   localparam int STALL_MAX      = 4;     // per-transfer idle draw, both sides
   localparam int LONG_HOLD      = 80;    // receiver back-pressure stretch
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer or register write
   localparam int RANDOM_ITEMS   = 1450;
   localparam int STEP_COUNT     = dats_pkg::NUM_STEPS_DEFAULT;

   // floor(127.5*sin(pi*j/128)), first quarter of the wave
   localparam logic [6:0] QUARTER_WAVE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,  7'd12,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
       7'd30,  7'd34,  7'd37,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,
       7'd60,  7'd62,  7'd65,  7'd68,  7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd83,
       7'd85,  7'd87,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98, 7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
      7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
      7'd126, 7'd127, 7'd127, 7'd127, 7'd127
   };

   typedef struct packed {
      logic [7:0] sample;
      logic [2:0] step;
   } tone_type;

   // Tone predictor and the queue of tones still owed by the block.
   class tone_scoreboard;
      bit        enable;
      bit [47:0] step_word [8];
      bit [11:0] bounds;
      bit [15:0] phase;
      bit [15:0] phase_inc;
      bit [31:0] remaining;
      bit [2:0]  step;
      bit        pattern;
      bit [7:0]  sample;
      bit [7:0]  wave_lut [256];
      tone_type  expected_tones [$];
      int        errors;

      function new();
         // Fill the lower half (129..255) first; the upper half (0..128) owns entry 128.
         for (int j = 1; j <= 64; j++) begin
            wave_lut[128 + j] = 8'd127 - 8'(QUARTER_WAVE[j]);
            wave_lut[256 - j] = 8'd127 - 8'(QUARTER_WAVE[j]);
         end
         for (int j = 0; j <= 64; j++) begin
            wave_lut[j]       = 8'd128 + 8'(QUARTER_WAVE[j]);
            wave_lut[128 - j] = 8'd128 + 8'(QUARTER_WAVE[j]);
         end
         enable       = 1'b1;
         step_word[0] = 48'd6751688597124;
         step_word[1] = 48'd7812;
         step_word[2] = 48'd9006546435337;
         step_word[3] = 48'd15625;
         step_word[4] = 48'd6751688604937;
         step_word[5] = 48'd15625;
         step_word[6] = '0;
         step_word[7] = '0;
         bounds       = 12'd2632;
         phase        = '0;
         phase_inc    = '0;
         remaining    = 32'd1;
         step         = 3'd1;
         pattern      = 1'b0;
         sample       = '0;
         errors       = 0;
      endfunction

      function void write_reg(dats_pkg::csr_index_type idx, bit [47:0] value);
         case (idx)
            dats_pkg::CSR_ENABLE: enable = value[0];
            dats_pkg::CSR_BOUNDS: bounds = value[11:0];
            default:    step_word[int'(idx) - int'(dats_pkg::CSR_STEP0)] = value;
         endcase
      endfunction

      // Start (stop_field 0) or stop (stop_field 1) of a pattern, clamped to the last step.
      function bit [2:0] bound(bit pat, bit stop_field);
         bit [2:0] v;
         v = bounds[(int'(pat) * 2 + int'(stop_field)) * 3 +: 3];
         if (v > STEP_COUNT - 1) v = 3'(STEP_COUNT - 1);
         return v;
      endfunction

      function void load_step();
         remaining = step_word[step][31:0];
         phase_inc = step_word[step][47:32];
      endfunction

      function void note_request(bit mode, bit sel);
         tone_type t;
         if (mode == dats_pkg::MODE_SWITCH) begin
            pattern = sel;
            step    = bound(sel, 1'b0);
            load_step();
         end else if (enable) begin
            remaining = remaining - 32'd1;
            if (remaining == 0) begin
               step = step + 3'd1;
               if (step > bound(pattern, 1'b1)) step = bound(pattern, 1'b0);
               load_step();
            end
            phase  = phase + phase_inc;
            sample = wave_lut[phase[15:8]];
         end
         t.sample = sample;
         t.step   = step;
         expected_tones.push_back(t);
      endfunction

      function void check_response(logic [15:0] data);
         tone_type want;
         if (expected_tones.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, expected none actual %h",
                     $time, data);
            return;
         end
         want = expected_tones.pop_front();
         if (data[7:0] !== want.sample) begin
            errors++;
            $display("%0t: sample_value mismatch, expected %0d actual %0d",
                     $time, want.sample, data[7:0]);
         end
         if (data[10:8] !== want.step) begin
            errors++;
            $display("%0t: current_step mismatch, expected %0d actual %0d",
                     $time, want.step, data[10:8]);
         end
      endfunction
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = '0;   // [0] pattern_select
   logic          req_tuser  = dats_pkg::MODE_TICK;  // [0] mode
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;         // [7:0] sample_value, [10:8] current_step
   logic          csr_we     = 1'b0;
   dats_pkg::csr_index_type csr_index = dats_pkg::CSR_ENABLE;
   logic [47:0]   csr_wdata  = '0;

   tone_scoreboard tones = new();

   // Register image written to the block; indexed by register code.
   logic [47:0] cfg_word [8];
   bit          no_idle      = 1'b0;  // both sides run without gaps
   bit          hold_request = 1'b0;  // ask the receiver for one long stall
   int          quiet_cycles = 0;

   dds_alarm_tone_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check every response transfer against the oldest predicted tone.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tones.check_response(rsp_tdata);
   end

   // Watchdog: end the run if no transfer or register write happens for too long.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** dds_alarm_tone_sequencer: FAILED **");
         $finish;
      end
   end

   // Receiver: draw a stall per transfer; honor one long hold-off on request.
   initial begin : receiver
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, STALL_MAX);
         if (hold_request) begin
            stall        = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   // Offer one request after a random gap; hold it until the block takes it.
   task automatic send_item(bit mode, bit sel);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, sel};
      do @(posedge clock); while (!req_tready);
      tones.note_request(mode, sel);
   endtask

   // Drop valid and wait until every predicted tone has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tones.expected_tones.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all eight registers back to back from the register image.
   task automatic program_regs();
      dats_pkg::csr_index_type idx;
      for (int r = 0; r < 8; r++) begin
         idx = dats_pkg::csr_index_type'(r);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= cfg_word[idx];
         @(posedge clock);
         tones.write_reg(idx, cfg_word[idx]);
      end
      csr_we <= 1'b0;
   endtask

   // Draw a fresh tone program; the first two phases take the extremes.
   task automatic draw_program(int phase_num);
      logic [2:0]  start0, stop0, start1, stop1;
      logic [31:0] dur;
      int          pick;
      cfg_word[dats_pkg::CSR_ENABLE] = 48'd1;
      if (phase_num == 0) begin
         for (int s = 0; s < 6; s++) cfg_word[int'(dats_pkg::CSR_STEP0) + s] = '1;
         cfg_word[dats_pkg::CSR_BOUNDS] = 48'hFFF;
      end else if (phase_num == 1) begin
         for (int s = 0; s < 6; s++) cfg_word[int'(dats_pkg::CSR_STEP0) + s] = '0;
         cfg_word[dats_pkg::CSR_BOUNDS] = '0;
      end else begin
         cfg_word[dats_pkg::CSR_ENABLE] = ($urandom_range(0, 9) != 0) ? 48'd1 : 48'd0;
         for (int s = 0; s < 6; s++) begin
            // Short durations keep the sequencer stepping; a few zero or long.
            pick = $urandom_range(0, 9);
            if (pick < 7)       dur = $urandom_range(1, 4);
            else if (pick == 7) dur = '0;
            else if (pick == 8) dur = $urandom_range(5, 40);
            else                dur = $urandom;
            cfg_word[int'(dats_pkg::CSR_STEP0) + s] = {16'($urandom), dur};
         end
         if ($urandom_range(0, 1) == 0) begin
            start0 = 3'($urandom_range(0, STEP_COUNT - 1));
            stop0  = 3'($urandom_range(start0, STEP_COUNT - 1));
            start1 = 3'($urandom_range(0, STEP_COUNT - 1));
            stop1  = 3'($urandom_range(start1, STEP_COUNT - 1));
            cfg_word[dats_pkg::CSR_BOUNDS] = {36'd0, stop1, start1, stop0, start0};
         end else begin
            cfg_word[dats_pkg::CSR_BOUNDS] = 48'($urandom_range(0, 4095));
         end
      end
   endtask

   initial begin : stimulus
      int items_sent;
      int count;
      bit mode;
      items_sent = 0;
      cfg_word[dats_pkg::CSR_ENABLE] = 48'd1;
      cfg_word[dats_pkg::CSR_STEP0]  = 48'd6751688597124;
      cfg_word[dats_pkg::CSR_STEP1]  = 48'd7812;
      cfg_word[dats_pkg::CSR_STEP2]  = 48'd9006546435337;
      cfg_word[dats_pkg::CSR_STEP3]  = 48'd15625;
      cfg_word[dats_pkg::CSR_STEP4]  = 48'd6751688604937;
      cfg_word[dats_pkg::CSR_STEP5]  = 48'd15625;
      cfg_word[dats_pkg::CSR_BOUNDS] = 48'd2632;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default program: the first tick rolls the reset counter into the next step.
      // A set select bit on a tick must be ignored.
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b1);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_SWITCH, 1'b1);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b1);
      send_item(dats_pkg::MODE_SWITCH, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      wait_drained();

      // Disabled: ticks freeze everything, a switch still loads its start step.
      cfg_word[dats_pkg::CSR_ENABLE] = 48'd0;
      program_regs();
      send_item(dats_pkg::MODE_TICK, 1'b1);
      send_item(dats_pkg::MODE_SWITCH, 1'b1);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      wait_drained();

      // Zero duration wraps the counter and holds the step; pattern 1 bounds
      // of 7 and 6 clamp to the last step, whose duration is all ones.
      cfg_word[dats_pkg::CSR_ENABLE] = 48'd1;
      cfg_word[dats_pkg::CSR_STEP0]  = {16'hFFFF, 32'd0};
      cfg_word[dats_pkg::CSR_STEP1]  = {16'h0100, 32'd2};
      cfg_word[dats_pkg::CSR_STEP4]  = {16'h4000, 32'd1};
      cfg_word[dats_pkg::CSR_STEP5]  = {16'h0001, 32'hFFFF_FFFF};
      cfg_word[dats_pkg::CSR_BOUNDS] = {36'd0, 3'd6, 3'd7, 3'd0, 3'd0};
      program_regs();
      send_item(dats_pkg::MODE_SWITCH, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_SWITCH, 1'b1);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      wait_drained();

      // Start after stop: pattern 0 runs 4 then falls back to 4 and holds there.
      cfg_word[dats_pkg::CSR_BOUNDS] = {36'd0, 3'd5, 3'd0, 3'd1, 3'd4};
      program_regs();
      send_item(dats_pkg::MODE_SWITCH, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);
      send_item(dats_pkg::MODE_TICK, 1'b0);

      // Random phases: drain, reprogram every register, then a burst of items.
      for (int phase_num = 0; items_sent < RANDOM_ITEMS; phase_num++) begin
         wait_drained();
         draw_program(phase_num);
         program_regs();
         no_idle = (phase_num % 5 == 3);
         // Stall the receiver while requests keep coming so the block backs up.
         if (phase_num == 2) hold_request = 1'b1;
         count = $urandom_range(30, 70);
         repeat (count) begin
            mode = ($urandom_range(0, 7) == 0) ? dats_pkg::MODE_SWITCH : dats_pkg::MODE_TICK;
            send_item(mode, 1'($urandom_range(0, 1)));
            items_sent++;
         end
      end

      wait_drained();
      tones.errors += tones.expected_tones.size();
      if (tones.errors == 0) begin
         $display("** dds_alarm_tone_sequencer: PASSED **");
      end else begin
         $display("** dds_alarm_tone_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
